FILE: hdl/pulse_dose_rate_meter_core_defines.svh
// ----------------------------------------------------------------------------
// pulse dose rate meter assertion macros
// shared property forms for the concurrent checks of the core
// ----------------------------------------------------------------------------
`ifndef PULSE_DOSE_RATE_METER_CORE_DEFINES_SVH
`define PULSE_DOSE_RATE_METER_CORE_DEFINES_SVH

// consequent checked in the same cycle
`define PDRM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdrm check failed: same-cycle implication");

// consequent checked in the cycle after
`define PDRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdrm check failed: next-cycle implication");

`endif

FILE: hdl/pdrm_pkg.sv
// ----------------------------------------------------------------------------
// pdrm_pkg
// shared constants, register map, state and command types of the dose meter
// ----------------------------------------------------------------------------
package pdrm_pkg;

    localparam int BINS           = 12;
    localparam int BIN_IDX_W      = $clog2(BINS);
    localparam int PRIORITY_INDEX = 3;
    localparam int DIV_W          = 32;
    localparam int DIV_CNT_W      = $clog2(DIV_W);
    localparam int CFG_ADDR_W     = 5;

    localparam logic [31:0] MS_PER_HOUR = 32'd3600000;
    localparam logic [9:0]  MS_PER_S    = 10'd1000;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_PULSE = 2'd0;
    localparam t_mode MODE_TICK  = 2'd1;
    localparam t_mode MODE_QUERY = 2'd2;
    localparam t_mode MODE_ALARM = 2'd3;

    typedef enum logic [2:0] {
        REG_IMPULSES_PER_UR,
        REG_MAX_BIN_SECONDS,
        REG_MIN_BIN_SECONDS,
        REG_MAX_BIN_PULSES,
        REG_MIN_PULSES_FOR_RESULT
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] impulses_per_ur;
        logic [7:0]  max_bin_seconds;
        logic [7:0]  min_bin_seconds;
        logic [15:0] max_bin_pulses;
        logic [15:0] min_pulses_for_result;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        impulses_per_ur:       16'd1,
        max_bin_seconds:       8'd30,
        min_bin_seconds:       8'd2,
        max_bin_pulses:        16'd100,
        min_pulses_for_result: 16'd40
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_MULT_DIV,
        S_PRODUCT,
        S_RATE_DIV,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic pulse;
        logic tick;
        logic start;
        logic mult_start;
        logic walk_step;
        logic prod;
        logic rate_start;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cached_nz;
        logic bin0_secs_nz;
        logic walk_hit;
        logic walk_last;
        logic div_busy;
    } t_dp_sts;

endpackage

FILE: hdl/pdrm_in_if.sv
// ----------------------------------------------------------------------------
// pdrm_in_if
// input word channel: mode, sensor state, millisecond fraction, alarm level
// ----------------------------------------------------------------------------
interface pdrm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        sensor_ready;
    logic [9:0]  millis_frac;
    logic [31:0] min_dose;

    modport source (output valid, mode, sensor_ready, millis_frac, min_dose, input ready);
    modport sink (input valid, mode, sensor_ready, millis_frac, min_dose, output ready);
endinterface

FILE: hdl/pdrm_out_if.sv
// ----------------------------------------------------------------------------
// pdrm_out_if
// result word channel: dose rate, valid flag, alarm flag
// ----------------------------------------------------------------------------
interface pdrm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] dose_rate;
    logic        dose_valid;
    logic        alarm;

    modport source (output valid, dose_rate, dose_valid, alarm, input ready);
    modport sink (input valid, dose_rate, dose_valid, alarm, output ready);
endinterface

FILE: hdl/pdrm_cfg.sv
// ----------------------------------------------------------------------------
// pdrm_cfg
// apb register file holding calibration and bin timing settings
// ----------------------------------------------------------------------------
module pdrm_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pdrm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output pdrm_pkg::t_cfg                  o_cfg
);
    import pdrm_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[CFG_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_sel)
                REG_IMPULSES_PER_UR:       n_cfg.impulses_per_ur       = pwdata[15:0];
                REG_MAX_BIN_SECONDS:       n_cfg.max_bin_seconds       = pwdata[7:0];
                REG_MIN_BIN_SECONDS:       n_cfg.min_bin_seconds       = pwdata[7:0];
                REG_MAX_BIN_PULSES:        n_cfg.max_bin_pulses        = pwdata[15:0];
                REG_MIN_PULSES_FOR_RESULT: n_cfg.min_pulses_for_result = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_IMPULSES_PER_UR:       prdata = {16'd0, r_cfg.impulses_per_ur};
            REG_MAX_BIN_SECONDS:       prdata = {24'd0, r_cfg.max_bin_seconds};
            REG_MIN_BIN_SECONDS:       prdata = {24'd0, r_cfg.min_bin_seconds};
            REG_MAX_BIN_PULSES:        prdata = {16'd0, r_cfg.max_bin_pulses};
            REG_MIN_PULSES_FOR_RESULT: prdata = {16'd0, r_cfg.min_pulses_for_result};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end
endmodule

FILE: hdl/pdrm_div.sv
// ----------------------------------------------------------------------------
// pdrm_div
// shared radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pdrm_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pdrm_pkg::DIV_W-1:0]     i_dividend,
    input  logic [pdrm_pkg::DIV_W-1:0]     i_divisor,
    output logic                           o_busy,
    output logic [pdrm_pkg::DIV_W-1:0]     o_quotient
);
    import pdrm_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_dsr;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 fits;

    // zero divisor always fits, so the quotient comes out all ones
    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        diff  = trial - {1'b0, r_dsr};
        fits  = trial >= {1'b0, r_dsr};
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end
endmodule

FILE: hdl/pdrm_dp.sv
// ----------------------------------------------------------------------------
// pdrm_dp
// bin history, query accumulator, rate arithmetic and result register
// ----------------------------------------------------------------------------
module pdrm_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pdrm_pkg::t_dp_cmd i_cmd,
    input  pdrm_pkg::t_cfg    i_cfg,
    input  logic [1:0]        i_mode,
    input  logic              i_sensor_ready,
    input  logic [9:0]        i_millis_frac,
    input  logic [31:0]       i_min_dose,
    output pdrm_pkg::t_dp_sts o_sts,
    output logic [31:0]       o_dose_rate,
    output logic              o_dose_valid,
    output logic              o_alarm
);
    import pdrm_pkg::*;

    logic [31:0]          r_bin_pulses [BINS];
    logic [7:0]           r_bin_seconds [BINS];
    logic [31:0]          r_cached;
    logic                 r_is_alarm;
    logic [9:0]           r_ms;
    logic [31:0]          r_min_dose;
    logic                 r_cache_hit;
    logic                 r_hit;
    logic [31:0]          r_acc_p;
    logic [15:0]          r_acc_s;
    logic [BIN_IDX_W-1:0] r_idx;
    logic [31:0]          r_num;
    logic [31:0]          r_den;
    logic [31:0]          r_dose_rate;
    logic                 r_dose_valid;
    logic                 r_alarm;

    logic                 pulse_take;
    logic [7:0]           sec_next;
    logic                 bin_close;
    logic [9:0]           ms_mod;
    logic [31:0]          sum_p;
    logic [15:0]          sum_s;
    logic                 walk_hit;
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIV_W-1:0]     div_divisor;
    logic                 div_busy;
    logic [DIV_W-1:0]     div_q;

    // first pulse of an empty bin is dropped unless the sensor is ready
    assign pulse_take = !((r_bin_pulses[0] == 32'd0) && !i_sensor_ready);
    assign sec_next   = r_bin_seconds[0] + 8'd1;
    assign bin_close  = (sec_next > i_cfg.max_bin_seconds) ||
                        ((r_bin_pulses[0] > {16'd0, i_cfg.max_bin_pulses}) &&
                         (sec_next > i_cfg.min_bin_seconds));
    assign ms_mod     = (i_millis_frac >= MS_PER_S) ? (i_millis_frac - MS_PER_S) : i_millis_frac;

    assign sum_p    = r_acc_p + r_bin_pulses[r_idx];
    assign sum_s    = r_acc_s + {8'd0, r_bin_seconds[r_idx]};
    assign walk_hit = sum_p >= {16'd0, i_cfg.min_pulses_for_result};

    assign div_start    = i_cmd.mult_start || i_cmd.rate_start;
    assign div_dividend = i_cmd.mult_start ? MS_PER_HOUR : r_num;
    assign div_divisor  = i_cmd.mult_start ? {16'd0, i_cfg.impulses_per_ur} : r_den;

    pdrm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    always_comb begin
        o_sts.cached_nz    = r_cached != 32'd0;
        o_sts.bin0_secs_nz = r_bin_seconds[0] != 8'd0;
        o_sts.walk_hit     = walk_hit;
        o_sts.walk_last    = r_idx == BIN_IDX_W'(BINS - 1);
        o_sts.div_busy     = div_busy;
    end

    assign o_dose_rate  = r_dose_rate;
    assign o_dose_valid = r_dose_valid;
    assign o_alarm      = r_alarm;

    // bin history, a closing bin keeps its final second count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BINS; i++) begin
                r_bin_pulses[i]  <= 32'd0;
                r_bin_seconds[i] <= 8'd0;
            end
        end else if (i_cmd.pulse) begin
            if (pulse_take) begin
                r_bin_pulses[0] <= r_bin_pulses[0] + 32'd1;
            end
        end else if (i_cmd.tick) begin
            if (bin_close) begin
                for (int i = 2; i < BINS; i++) begin
                    r_bin_pulses[i]  <= r_bin_pulses[i-1];
                    r_bin_seconds[i] <= r_bin_seconds[i-1];
                end
                r_bin_pulses[1]  <= r_bin_pulses[0];
                r_bin_seconds[1] <= sec_next;
                r_bin_pulses[0]  <= 32'd0;
                r_bin_seconds[0] <= 8'd0;
            end else begin
                r_bin_seconds[0] <= sec_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cached <= 32'd0;
        end else if (i_cmd.tick) begin
            r_cached <= 32'd0;
        end else if (i_cmd.out_load && !r_is_alarm && !r_cache_hit && r_hit) begin
            r_cached <= div_q;
        end
    end

    // query and alarm working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_is_alarm  <= i_mode == MODE_ALARM;
            r_ms        <= ms_mod;
            r_min_dose  <= i_min_dose;
            r_cache_hit <= r_cached != 32'd0;
            r_idx       <= '0;
            if (i_mode == MODE_ALARM) begin
                r_acc_p <= r_bin_pulses[0];
                r_acc_s <= {8'd0, r_bin_seconds[0]};
                r_hit   <= r_bin_seconds[0] != 8'd0;
            end else begin
                r_acc_p <= 32'd0;
                r_acc_s <= 16'd0;
                r_hit   <= 1'b0;
            end
        end else if (i_cmd.walk_step) begin
            r_idx <= r_idx + 1'b1;
            r_hit <= walk_hit;
            if (!walk_hit && (r_idx == BIN_IDX_W'(PRIORITY_INDEX))) begin
                r_acc_p <= {sum_p[30:0], 1'b0};
                r_acc_s <= {sum_s[14:0], 1'b0};
            end else begin
                r_acc_p <= sum_p;
                r_acc_s <= sum_s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod) begin
            r_num <= r_acc_p * div_q;
            r_den <= {16'd0, r_acc_s} * {22'd0, MS_PER_S} + {22'd0, r_ms};
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_is_alarm) begin
                r_dose_rate  <= 32'd0;
                r_dose_valid <= 1'b0;
                r_alarm      <= r_hit && (div_q >= r_min_dose);
            end else if (r_cache_hit) begin
                r_dose_rate  <= r_cached;
                r_dose_valid <= 1'b1;
                r_alarm      <= 1'b0;
            end else begin
                r_dose_rate  <= r_hit ? div_q : 32'd0;
                r_dose_valid <= r_hit;
                r_alarm      <= 1'b0;
            end
        end
    end
endmodule

FILE: hdl/pdrm_ctrl.sv
// ----------------------------------------------------------------------------
// pdrm_ctrl
// sequencer for bin updates, query walk, divider passes and result hand-off
// ----------------------------------------------------------------------------
module pdrm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_mode,
    input  logic              i_out_ready,
    input  pdrm_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output pdrm_pkg::t_dp_cmd o_cmd
);
    import pdrm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_mode)
                        MODE_PULSE: n_state = S_IDLE;
                        MODE_TICK:  n_state = S_IDLE;
                        MODE_QUERY: n_state = i_sts.cached_nz ? S_RESULT : S_WALK;
                        MODE_ALARM: n_state = i_sts.bin0_secs_nz ? S_MULT_DIV : S_RESULT;
                    endcase
                end
            end
            S_WALK: begin
                priority if (i_sts.walk_hit) begin
                    n_state = S_MULT_DIV;
                end else if (i_sts.walk_last) begin
                    n_state = S_RESULT;
                end
            end
            S_MULT_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_PRODUCT;
                end
            end
            S_PRODUCT:  n_state = S_RATE_DIV;
            S_RATE_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_mode)
                        MODE_PULSE: o_cmd.pulse = 1'b1;
                        MODE_TICK:  o_cmd.tick  = 1'b1;
                        MODE_QUERY, MODE_ALARM: begin
                            o_cmd.start      = 1'b1;
                            o_cmd.mult_start = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK:     o_cmd.walk_step = 1'b1;
            S_MULT_DIV: o_cmd.prod = !i_sts.div_busy;
            S_PRODUCT:  o_cmd.rate_start = 1'b1;
            S_RATE_DIV: ;
            S_RESULT:   o_cmd.out_load = out_free;
            default: ;
        endcase
    end

    always_comb begin
        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

FILE: hdl/pulse_dose_rate_meter_core.sv
// ----------------------------------------------------------------------------
// pulse_dose_rate_meter_core
// detector pulse dose-rate meter with bin history, query and alarm check
// ----------------------------------------------------------------------------
// usage
//   i_in carries one word per event: pulse, second tick, dose query or alarm
//   check. pulse and tick words update the bin history at acceptance and give
//   no result; i_in.ready stays high for the next word.
//   query and alarm words each give one word on o_out. a query with a cached
//   dose goes straight to the result step; a computed query or alarm check
//   takes two passes of the shared radix-2 divider (calibration multiplier,
//   then the rate); the bin walk over up to 12 bins runs under the first
//   pass. one item is in work at a time, so a new word is accepted only after
//   the last query or alarm check has left its result step.
//   o_out has an output register: a new word is accepted while the last
//   result waits; a stalled receiver holds the next result in its final step.
//   settings sit on the apb port; the user must write them only while the block is idle, the block does not enforce it.
//   reset clears the bin history, cached dose and handshake state at once.
// ----------------------------------------------------------------------------
`include "pulse_dose_rate_meter_core_defines.svh"

module pulse_dose_rate_meter_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pdrm_in_if.sink                         i_in,
    pdrm_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pdrm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import pdrm_pkg::*;

    t_cfg    cfg;
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    pdrm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pdrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_mode      (i_in.mode),
        .i_out_ready (o_out.ready),
        .i_sts       (dp_sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (dp_cmd)
    );

    pdrm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_cfg          (cfg),
        .i_mode         (i_in.mode),
        .i_sensor_ready (i_in.sensor_ready),
        .i_millis_frac  (i_in.millis_frac),
        .i_min_dose     (i_in.min_dose),
        .o_sts          (dp_sts),
        .o_dose_rate    (o_out.dose_rate),
        .o_dose_valid   (o_out.dose_valid),
        .o_alarm        (o_out.alarm)
    );

    `PDRM_ASSERT_NEXT(a_result_word_holds_input, i_clk, i_rst_n,
        i_in.valid && i_in.ready && (i_in.mode == MODE_QUERY || i_in.mode == MODE_ALARM),
        !i_in.ready)
    `PDRM_ASSERT_NEXT(a_update_word_no_stall, i_clk, i_rst_n,
        i_in.valid && i_in.ready && (i_in.mode == MODE_PULSE || i_in.mode == MODE_TICK),
        i_in.ready)
    `PDRM_ASSERT_SAME(a_load_only_when_free, i_clk, i_rst_n,
        dp_cmd.out_load, !o_out.valid || o_out.ready)
    `PDRM_ASSERT_SAME(a_alarm_word_no_dose, i_clk, i_rst_n,
        o_out.valid && o_out.alarm, !o_out.dose_valid && o_out.dose_rate == 32'd0)
endmodule

FILE: tb/pulse_dose_rate_meter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_dose_rate_meter_core_test
// self-checking bench for the dose meter core: a queue-fed driver sends
// pulse, tick, query and alarm words in random bursts, a scoreboard model of
// the bin history predicts every reading, and a monitor compares them while
// the receiver stalls on its own pattern, once for a long stretch
// ----------------------------------------------------------------------------
module pulse_dose_rate_meter_core_test;
    import pdrm_pkg::*;

    localparam logic [2:0] UNMAPPED_REG = 3'd5;
    localparam int         SETTLE_CYCLES = 100;
    localparam int         LONG_HOLD = 800;

    typedef struct packed {
        t_mode       mode;
        logic        sensor_ready;
        logic [9:0]  millis_frac;
        logic [31:0] min_dose;
    } t_word;

    typedef struct packed {
        logic [31:0] dose_rate;
        logic        dose_valid;
        logic        alarm;
    } t_reading;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        drv_valid = 1'b0;
    t_word       bus_word = '0;
    logic        rcv_ready = 1'b0;

    pdrm_in_if  in_if ();
    pdrm_out_if out_if ();

    assign in_if.valid        = drv_valid;
    assign in_if.mode         = bus_word.mode;
    assign in_if.sensor_ready = bus_word.sensor_ready;
    assign in_if.millis_frac  = bus_word.millis_frac;
    assign in_if.min_dose     = bus_word.min_dose;
    assign out_if.ready       = rcv_ready;

    pulse_dose_rate_meter_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // scoreboard copy of the meter
    logic [31:0] bin_count [BINS] = '{default: '0};
    logic [7:0]  bin_age [BINS] = '{default: '0};
    logic [31:0] held_dose = '0;
    t_cfg        meter_cfg = CFG_RESET;

    t_word       pending_words [$];
    t_reading    expected_readings [$];

    int n_words_in = 0;
    int n_pulses = 0;
    int n_ticks = 0;
    int n_queries = 0;
    int n_checks = 0;
    int n_readings = 0;
    int n_doses = 0;
    int n_alarms = 0;
    int n_in_stalls = 0;
    int n_settings = 0;
    int n_mismatches = 0;

    int gap_left = 0;
    int burst_left = 1;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int rcv_style = 0;
    int style_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rate_per_hour(input logic [31:0] pulses,
                                                  input logic [15:0] secs,
                                                  input logic [9:0] ms);
        logic [31:0] mult;
        logic [31:0] num;
        logic [31:0] den;
        mult = (meter_cfg.impulses_per_ur == '0) ? 32'hFFFF_FFFF
                                                 : MS_PER_HOUR / 32'(meter_cfg.impulses_per_ur);
        num = pulses * mult;
        den = 32'(secs) * 32'd1000 + 32'(ms);
        return (den == '0) ? 32'hFFFF_FFFF : num / den;
    endfunction

    function automatic void meter_step(input t_word w);
        logic [9:0]  ms;
        logic [31:0] psum;
        logic [15:0] ssum;
        logic        hit;
        t_reading    r;
        int          i;
        ms = (w.millis_frac >= MS_PER_S) ? w.millis_frac - MS_PER_S : w.millis_frac;
        r = '0;
        case (w.mode)
            MODE_PULSE: begin
                n_pulses++;
                if (bin_count[0] != '0 || w.sensor_ready)
                    bin_count[0] = bin_count[0] + 32'd1;
            end
            MODE_TICK: begin
                n_ticks++;
                held_dose = '0;
                bin_age[0] = bin_age[0] + 8'd1;
                if (bin_age[0] > meter_cfg.max_bin_seconds ||
                    (bin_count[0] > 32'(meter_cfg.max_bin_pulses) &&
                     bin_age[0] > meter_cfg.min_bin_seconds)) begin
                    for (i = BINS - 1; i > 0; i--) begin
                        bin_count[i] = bin_count[i-1];
                        bin_age[i] = bin_age[i-1];
                    end
                    bin_count[0] = '0;
                    bin_age[0] = '0;
                end
            end
            MODE_QUERY: begin
                n_queries++;
                if (held_dose != '0) begin
                    r.dose_rate = held_dose;
                    r.dose_valid = 1'b1;
                end else begin
                    psum = '0;
                    ssum = '0;
                    hit = 1'b0;
                    for (i = 0; i < BINS && !hit; i++) begin
                        psum = psum + bin_count[i];
                        ssum = ssum + 16'(bin_age[i]);
                        if (psum >= 32'(meter_cfg.min_pulses_for_result)) begin
                            hit = 1'b1;
                        end else if (i == PRIORITY_INDEX) begin
                            psum = psum * 32'd2;
                            ssum = ssum * 16'd2;
                        end
                    end
                    if (hit) begin
                        r.dose_rate = rate_per_hour(psum, ssum, ms);
                        r.dose_valid = 1'b1;
                        held_dose = r.dose_rate;
                    end
                end
                expected_readings.push_back(r);
            end
            default: begin
                n_checks++;
                if (bin_age[0] != '0)
                    r.alarm = rate_per_hour(bin_count[0], 16'(bin_age[0]), ms) >= w.min_dose;
                expected_readings.push_back(r);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH reading %0d at %0t: %s got %0h, expected %0h",
                 n_readings, $time, what, got, want);
        n_mismatches++;
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_IMPULSES_PER_UR:       meter_cfg.impulses_per_ur = val[15:0];
            REG_MAX_BIN_SECONDS:       meter_cfg.max_bin_seconds = val[7:0];
            REG_MIN_BIN_SECONDS:       meter_cfg.min_bin_seconds = val[7:0];
            REG_MAX_BIN_PULSES:        meter_cfg.max_bin_pulses = val[15:0];
            REG_MIN_PULSES_FOR_RESULT: meter_cfg.min_pulses_for_result = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [15:0] imp, input logic [7:0] max_s,
                                 input logic [7:0] min_s, input logic [15:0] max_p,
                                 input logic [15:0] min_p);
        cfg_write(REG_IMPULSES_PER_UR, 32'(imp));
        cfg_write(REG_MAX_BIN_SECONDS, 32'(max_s));
        cfg_write(REG_MIN_BIN_SECONDS, 32'(min_s));
        cfg_write(REG_MAX_BIN_PULSES, 32'(max_p));
        cfg_write(REG_MIN_PULSES_FOR_RESULT, 32'(min_p));
        n_settings++;
    endtask

    task automatic push_word(input t_mode mode, input logic rdy, input logic [9:0] ms,
                             input logic [31:0] dose);
        t_word w;
        w.mode = mode;
        w.sensor_ready = rdy;
        w.millis_frac = ms;
        w.min_dose = dose;
        pending_words.push_back(w);
    endtask

    task automatic push_random(input int count, input int pct_pulse, input int pct_tick,
                               input int pct_query);
        int    k;
        int    pick;
        t_mode mode;
        logic [31:0] dose;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < pct_pulse)
                mode = MODE_PULSE;
            else if (pick < pct_pulse + pct_tick)
                mode = MODE_TICK;
            else if (pick < pct_pulse + pct_tick + pct_query)
                mode = MODE_QUERY;
            else
                mode = MODE_ALARM;
            dose = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 100000);
            push_word(mode, $urandom_range(0, 4) != 0, 10'($urandom_range(0, 1023)), dose);
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || drv_valid || expected_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // word driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && in_if.ready) begin
                meter_step(bus_word);
                n_words_in++;
            end else if (drv_valid) begin
                n_in_stalls++;
            end
            if (!drv_valid || in_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    drv_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    bus_word <= pending_words.pop_front();
                    drv_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, one long hold once traffic is under way
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rcv_ready <= 1'b0;
        end else begin
            if (!hold_done && n_words_in >= 200) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (style_left == 0) begin
                rcv_style = $urandom_range(0, 2);
                style_left = $urandom_range(20, 150);
            end else begin
                style_left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                rcv_ready <= 1'b0;
            end else begin
                case (rcv_style)
                    0: rcv_ready <= 1'b1;
                    1: rcv_ready <= 1'($urandom_range(0, 1));
                    default: rcv_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // reading monitor
    t_reading want;
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("unexpected reading", out_if.dose_rate, '0);
            end else begin
                want = expected_readings.pop_front();
                if (out_if.dose_rate !== want.dose_rate)
                    report_mismatch("dose_rate", out_if.dose_rate, want.dose_rate);
                if (out_if.dose_valid !== want.dose_valid)
                    report_mismatch("dose_valid", 32'(out_if.dose_valid), 32'(want.dose_valid));
                if (out_if.alarm !== want.alarm)
                    report_mismatch("alarm", 32'(out_if.alarm), 32'(want.alarm));
                if (want.dose_valid)
                    n_doses++;
                if (want.alarm)
                    n_alarms++;
            end
            n_readings++;
        end
    end

    initial begin
        int k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero calibration, fastest closing, any pulse gives a value
        load_settings(16'd0, 8'd1, 8'd0, 16'd0, 16'd1);
        cfg_write(UNMAPPED_REG, 32'hFFFF_FFFF);
        push_word(MODE_QUERY, 1'b1, 10'd0, 32'd0);
        push_word(MODE_ALARM, 1'b1, 10'd500, 32'd0);
        push_word(MODE_PULSE, 1'b0, 10'd0, 32'd0);
        push_word(MODE_QUERY, 1'b0, 10'd1, 32'd0);
        push_word(MODE_PULSE, 1'b1, 10'd0, 32'd0);
        push_word(MODE_PULSE, 1'b0, 10'd0, 32'd0);
        push_word(MODE_QUERY, 1'b1, 10'd0, 32'd0);
        push_word(MODE_QUERY, 1'b1, 10'd5, 32'd0);
        push_word(MODE_TICK, 1'b1, 10'd0, 32'd0);
        push_word(MODE_QUERY, 1'b1, 10'd1023, 32'hFFFF_FFFF);
        push_word(MODE_TICK, 1'b0, 10'd0, 32'd0);
        push_word(MODE_ALARM, 1'b1, 10'd999, 32'd0);
        push_word(MODE_ALARM, 1'b1, 10'd0, 32'hFFFF_FFFF);
        push_word(MODE_PULSE, 1'b1, 10'd0, 32'd0);
        push_word(MODE_ALARM, 1'b1, 10'd1000, 32'hAAAA_AAAA);
        push_word(MODE_ALARM, 1'b0, 10'd341, 32'h5555_5555);
        push_word(MODE_TICK, 1'b1, 10'd0, 32'd0);
        push_word(MODE_QUERY, 1'b1, 10'd1000, 32'd0);
        push_word(MODE_QUERY, 1'b1, 10'd682, 32'd0);
        wait_drained();

        load_settings(16'd1, 8'd30, 8'd2, 16'd100, 16'd40);
        push_random(120, 55, 20, 15);
        wait_drained();

        load_settings(16'($urandom_range(1, 100)), 8'd3, 8'd1, 16'd5, 16'd8);
        push_random(120, 50, 22, 18);
        wait_drained();

        // long-lived bin: seconds roll over past 255
        load_settings(16'd3, 8'd255, 8'd255, 16'd0, 16'd10);
        for (k = 0; k < 5; k++)
            push_word(MODE_PULSE, 1'b1, 10'd0, 32'd0);
        for (k = 0; k < 260; k++) begin
            push_word(MODE_TICK, 1'b1, 10'd0, 32'd0);
            if (k % 52 == 0 || k >= 254) begin
                push_word(MODE_ALARM, 1'b1, 10'($urandom_range(0, 1023)), $urandom_range(0, 5000));
                push_word(MODE_QUERY, 1'b1, 10'($urandom_range(0, 1023)), 32'd0);
            end
        end
        wait_drained();

        load_settings(16'd65535, 8'd254, 8'd254, 16'd65535, 16'd65535);
        push_random(100, 55, 20, 15);
        wait_drained();

        for (k = 0; k < 2; k++) begin
            load_settings(16'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 65535)
                                                          : $urandom_range(1, 20)),
                          8'($urandom_range(1, 20)), 8'($urandom_range(0, 10)),
                          16'($urandom_range(0, 60)), 16'($urandom_range(1, 80)));
            push_random(100, 50, 20, 18);
            wait_drained();
        end

        $display("run covered %0d words (%0d pulses, %0d ticks, %0d queries, %0d alarm checks)",
                 n_words_in, n_pulses, n_ticks, n_queries, n_checks);
        $display("over %0d register settings: %0d readings, %0d with a dose, %0d alarms, %0d %s",
                 n_settings, n_readings, n_doses, n_alarms, n_in_stalls,
                 "input stall cycles");
        if (n_mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #(64'd12_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/pdrm_pkg.sv
hdl/pdrm_in_if.sv
hdl/pdrm_out_if.sv
hdl/pdrm_cfg.sv
hdl/pdrm_div.sv
hdl/pdrm_dp.sv
hdl/pdrm_ctrl.sv
hdl/pulse_dose_rate_meter_core.sv
tb/pulse_dose_rate_meter_core_test.sv
